>>> hdl/assert_macros.svh
// shared assertion forms, all sampled on the rising edge and off while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen
`define CHK_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/crcpl_pkg.sv
package crcpl_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int CFG_IDX_W            = 3;
    localparam int CFG_DATA_W           = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_PULSE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PULSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_GAP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TOGGLES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC   = 3'd6;

    // register reset values
    localparam logic [15:0] RST_ONE_PULSE      = 16'd600;
    localparam logic [15:0] RST_ZERO_PULSE     = 16'd150;
    localparam logic [15:0] RST_BIT_GAP        = 16'd250;
    localparam logic [15:0] RST_FRAME_GAP      = 16'd2000;
    localparam logic [15:0] RST_BLINK_INTERVAL = 16'd100;
    localparam logic [7:0]  RST_BLINK_TOGGLES  = 8'd10;
    localparam logic [7:0]  RST_EXPECTED_CRC   = 8'hF4;

    localparam logic [2:0] BIT_MSB = 3'd7;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_RESULT = 1'b1;
    localparam logic MSG_MAIN   = 1'b0;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_LIT   = 5'b00010,
        PH_GAP   = 5'b00100,
        PH_FRAME = 5'b01000,
        PH_BLINK = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       req_type;
        logic [7:0] crc_value;
        logic       message_id;
    } t_in_word;

    typedef struct packed {
        logic       led_lit;
        logic       accepted;
        logic       busy_res;
        logic       check_done;
        logic       check_ok;
        logic [7:0] main_crc_out;
        logic [7:0] altered_crc_out;
    } t_out_word;

    typedef struct packed {
        logic [15:0] one_pulse_ticks;
        logic [15:0] zero_pulse_ticks;
        logic [15:0] bit_gap_ticks;
        logic [15:0] frame_gap_ticks;
        logic [15:0] blink_interval_ticks;
        logic [7:0]  blink_toggle_count;
        logic [7:0]  expected_crc;
    } t_cfg;

endpackage

>>> hdl/crcpl_cfg.sv
module crcpl_cfg
    import crcpl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_pulse_ticks      <= RST_ONE_PULSE;
            r_cfg.zero_pulse_ticks     <= RST_ZERO_PULSE;
            r_cfg.bit_gap_ticks        <= RST_BIT_GAP;
            r_cfg.frame_gap_ticks      <= RST_FRAME_GAP;
            r_cfg.blink_interval_ticks <= RST_BLINK_INTERVAL;
            r_cfg.blink_toggle_count   <= RST_BLINK_TOGGLES;
            r_cfg.expected_crc         <= RST_EXPECTED_CRC;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ONE_PULSE:      r_cfg.one_pulse_ticks      <= i_cfg_wdata;
                CFG_ZERO_PULSE:     r_cfg.zero_pulse_ticks     <= i_cfg_wdata;
                CFG_BIT_GAP:        r_cfg.bit_gap_ticks        <= i_cfg_wdata;
                CFG_FRAME_GAP:      r_cfg.frame_gap_ticks      <= i_cfg_wdata;
                CFG_BLINK_INTERVAL: r_cfg.blink_interval_ticks <= i_cfg_wdata;
                CFG_BLINK_TOGGLES:  r_cfg.blink_toggle_count   <= i_cfg_wdata[7:0];
                CFG_EXPECTED_CRC:   r_cfg.expected_crc         <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/crcpl_engine.sv
`include "assert_macros.svh"

module crcpl_engine
    import crcpl_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    localparam int W  = TICK_COUNT_WIDTH;
    localparam int DW = (W < 16) ? W : 16;

    typedef enum logic [1:0] {
        K_LIT,
        K_GAP,
        K_FRAME,
        K_IDLE
    } t_kind;

    logic [1:0]   r_rcv_mask, n_rcv_mask;
    logic [7:0]   r_main, n_main;
    logic [7:0]   r_alt, n_alt;
    logic         r_verdict, n_verdict;
    logic [7:0]   r_lat_main, n_lat_main;
    logic [7:0]   r_lat_alt, n_lat_alt;
    t_phase       r_phase, n_phase;
    logic [2:0]   r_bit, n_bit;
    logic [W-1:0] r_cnt, n_cnt;
    logic [7:0]   r_toggles, n_toggles;
    logic         r_led, n_led;

    logic         w_accepted, w_done;
    logic [W-1:0] w_d_one, w_d_zero, w_d_gap, w_d_frame, w_d_int;
    logic [7:0]   w_pnz;
    logic         s_go, b_go, s_found, s_frame;
    t_kind        s_kind;
    logic [2:0]   s_bit, s_j;

    function automatic logic [W-1:0] f_dur(input logic [15:0] v);
        f_dur = W'(v[DW-1:0]);
    endfunction

    assign w_d_one   = f_dur(i_cfg.one_pulse_ticks);
    assign w_d_zero  = f_dur(i_cfg.zero_pulse_ticks);
    assign w_d_gap   = f_dur(i_cfg.bit_gap_ticks);
    assign w_d_frame = f_dur(i_cfg.frame_gap_ticks);
    assign w_d_int   = f_dur(i_cfg.blink_interval_ticks);

    always_comb begin
        n_rcv_mask = r_rcv_mask;
        n_main     = r_main;
        n_alt      = r_alt;
        n_verdict  = r_verdict;
        n_lat_main = r_lat_main;
        n_lat_alt  = r_lat_alt;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_cnt      = r_cnt;
        n_toggles  = r_toggles;
        n_led      = r_led;
        w_accepted = 1'b0;
        w_done     = 1'b0;
        s_go       = 1'b0;
        b_go       = 1'b0;
        s_kind     = K_IDLE;
        s_bit      = r_bit;
        s_found    = 1'b0;
        s_j        = 3'd0;
        s_frame    = 1'b0;

        if (i_fire) begin
            if (i_word.req_type == REQ_TICK) begin
                if (r_phase != PH_IDLE) begin
                    if (r_cnt > W'(1)) begin
                        n_cnt = r_cnt - W'(1);
                    end else begin
                        // phase runs out on this tick
                        case (r_phase)
                            PH_LIT: begin
                                s_go   = 1'b1;
                                s_kind = K_GAP;
                            end
                            PH_GAP: begin
                                s_go = 1'b1;
                                if (r_bit != 3'd0) begin
                                    s_kind = K_LIT;
                                    s_bit  = r_bit - 3'd1;
                                end else begin
                                    s_kind = K_FRAME;
                                end
                            end
                            PH_FRAME: begin
                                s_go   = 1'b1;
                                s_kind = K_IDLE;
                            end
                            PH_BLINK: b_go = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end else if (r_phase == PH_IDLE) begin
                w_accepted = 1'b1;
                if (i_word.message_id == MSG_MAIN) begin
                    n_main        = i_word.crc_value;
                    n_rcv_mask[0] = 1'b1;
                end else begin
                    n_alt         = i_word.crc_value;
                    n_rcv_mask[1] = 1'b1;
                end
                if (n_rcv_mask == 2'b11) begin
                    w_done     = 1'b1;
                    n_lat_main = n_main;
                    n_lat_alt  = n_alt;
                    n_verdict  = (n_main == i_cfg.expected_crc) && (n_alt != n_main);
                    n_rcv_mask = 2'b00;
                    if (n_verdict) begin
                        s_go   = 1'b1;
                        s_kind = K_LIT;
                        s_bit  = BIT_MSB;
                    end else begin
                        b_go      = 1'b1;
                        n_toggles = i_cfg.blink_toggle_count;
                    end
                end
            end
        end

        // lit length per bit is nonzero
        for (int j = 0; j < 8; j++) begin
            w_pnz[j] = n_lat_main[j] ? (w_d_one != '0) : (w_d_zero != '0);
        end
        // highest lower bit with a visible pulse, used when the gap is empty
        for (int j = 0; j < 8; j++) begin
            if (3'(j) < s_bit && w_pnz[j]) begin
                s_found = 1'b1;
                s_j     = 3'(j);
            end
        end

        if (s_go) begin
            case (s_kind)
                K_LIT, K_GAP: begin
                    if (s_kind == K_LIT && w_pnz[s_bit]) begin
                        n_phase = PH_LIT;
                        n_bit   = s_bit;
                        n_led   = 1'b1;
                        n_cnt   = n_lat_main[s_bit] ? w_d_one : w_d_zero;
                    end else if (w_d_gap != '0) begin
                        n_phase = PH_GAP;
                        n_bit   = s_bit;
                        n_led   = 1'b0;
                        n_cnt   = w_d_gap;
                    end else if (s_found) begin
                        n_phase = PH_LIT;
                        n_bit   = s_j;
                        n_led   = 1'b1;
                        n_cnt   = n_lat_main[s_j] ? w_d_one : w_d_zero;
                    end else begin
                        s_frame = 1'b1;
                    end
                end
                K_FRAME: s_frame = 1'b1;
                default: begin
                    n_phase = PH_IDLE;
                    n_bit   = BIT_MSB;
                    n_led   = 1'b0;
                    n_cnt   = '0;
                end
            endcase
            if (s_frame) begin
                if (w_d_frame != '0) begin
                    n_phase = PH_FRAME;
                    n_bit   = 3'd0;
                    n_led   = 1'b0;
                    n_cnt   = w_d_frame;
                end else begin
                    n_phase = PH_IDLE;
                    n_bit   = BIT_MSB;
                    n_led   = 1'b0;
                    n_cnt   = '0;
                end
            end
        end

        if (b_go) begin
            // an empty interval burns through every toggle at once
            if (n_toggles != 8'd0 && w_d_int != '0) begin
                n_phase   = PH_BLINK;
                n_toggles = n_toggles - 8'd1;
                n_led     = ~r_led;
                n_cnt     = w_d_int;
            end else begin
                n_phase   = PH_IDLE;
                n_toggles = 8'd0;
                n_led     = 1'b0;
                n_cnt     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcv_mask <= 2'b00;
            r_main     <= 8'd0;
            r_alt      <= 8'd0;
            r_verdict  <= 1'b0;
            r_lat_main <= 8'd0;
            r_lat_alt  <= 8'd0;
            r_phase    <= PH_IDLE;
            r_bit      <= BIT_MSB;
            r_cnt      <= '0;
            r_toggles  <= 8'd0;
            r_led      <= 1'b0;
        end else begin
            r_rcv_mask <= n_rcv_mask;
            r_main     <= n_main;
            r_alt      <= n_alt;
            r_verdict  <= n_verdict;
            r_lat_main <= n_lat_main;
            r_lat_alt  <= n_lat_alt;
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_cnt      <= n_cnt;
            r_toggles  <= n_toggles;
            r_led      <= n_led;
        end
    end

    assign o_result.led_lit         = n_led;
    assign o_result.accepted        = w_accepted;
    assign o_result.busy_res        = (n_phase != PH_IDLE);
    assign o_result.check_done      = w_done;
    assign o_result.check_ok        = n_verdict;
    assign o_result.main_crc_out    = n_lat_main;
    assign o_result.altered_crc_out = n_lat_alt;

    `CHK_ASSERT(a_busy_cnt, i_clk, i_rst_n, r_phase != PH_IDLE |-> r_cnt != '0, "busy with empty counter")
    `CHK_NEVER(a_idle_dark, i_clk, i_rst_n, r_phase == PH_IDLE && (r_led || r_bit != BIT_MSB), "idle not parked")
    `CHK_ASSERT(a_pair_clr, i_clk, i_rst_n, i_fire && w_done |=> r_rcv_mask == 2'b00, "pair not cleared")

endmodule

>>> hdl/crc_pair_check_led_pulse_coder_core.sv
// an accepted word waits in the input stage; its result word is registered in the output stage
// throughput: one word per cycle unless output stalls; input and output stages run concurrently
// the input stall rises only when both stages are full and the output is stalled
// reset: synchronous active low, clears pair state, display, led and registers
// to their defaults; both stages come up empty
`include "assert_macros.svh"

module crc_pair_check_led_pulse_coder_core
    import crcpl_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic      r_in_vld, n_in_vld;
    t_in_word  r_in_word;
    logic      r_out_vld, n_out_vld;
    t_out_word r_out_word;
    logic      w_adv, w_in_fire;
    t_cfg      w_cfg;
    t_out_word w_result;

    // input stage moves into the result register
    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (w_in_fire) begin
            n_in_vld = 1'b1;
        end else if (w_adv) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (w_adv) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_word <= i_in_data;
        end
        if (w_adv) begin
            r_out_word <= w_result;
        end
    end

    crcpl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    crcpl_engine #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_word   (r_in_word),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_word;

    `CHK_ASSERT(a_adv_out, i_clk, i_rst_n, w_adv |=> r_out_vld, "advanced word missing at output")

endmodule

>>> tb/sv/crcpl_checker.sv
module crcpl_checker
    import crcpl_pkg::*;
#(
    parameter int TW = TICK_COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg            cfg_q;
    logic [1:0]      pair_seen;
    logic [7:0]      main_held;
    logic [7:0]      alt_held;
    logic [7:0]      main_shown;
    logic [7:0]      alt_shown;
    logic            pass_q;
    t_phase          phase_q;
    logic [2:0]      bit_idx;
    logic [TW-1:0]   ticks_left;
    logic [7:0]      toggles_q;
    logic            led_q;
    t_out_word       expected_words[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic void start_bit();
        led_q      = 1'b1;
        phase_q    = PH_LIT;
        ticks_left = main_shown[bit_idx] ? TW'(cfg_q.one_pulse_ticks)
                                         : TW'(cfg_q.zero_pulse_ticks);
    endfunction

    // walk through every phase whose duration is already used up
    function automatic void settle();
        while (phase_q != PH_IDLE && ticks_left == '0) begin
            case (phase_q)
                PH_LIT: begin
                    led_q      = 1'b0;
                    phase_q    = PH_GAP;
                    ticks_left = TW'(cfg_q.bit_gap_ticks);
                end
                PH_GAP: begin
                    if (bit_idx != 3'd0) begin
                        bit_idx = bit_idx - 3'd1;
                        start_bit();
                    end else begin
                        phase_q    = PH_FRAME;
                        ticks_left = TW'(cfg_q.frame_gap_ticks);
                    end
                end
                PH_BLINK: begin
                    if (toggles_q != 8'd0) begin
                        toggles_q  = toggles_q - 8'd1;
                        led_q      = ~led_q;
                        ticks_left = TW'(cfg_q.blink_interval_ticks);
                    end else begin
                        led_q      = 1'b0;
                        phase_q    = PH_IDLE;
                        ticks_left = '0;
                    end
                end
                default: begin
                    led_q      = 1'b0;
                    phase_q    = PH_IDLE;
                    bit_idx    = BIT_MSB;
                    ticks_left = '0;
                end
            endcase
        end
    endfunction

    function automatic t_out_word predict_word(input t_in_word w);
        t_out_word r;
        r = '0;
        if (w.req_type == REQ_TICK) begin
            if (phase_q != PH_IDLE) begin
                if (ticks_left != '0)
                    ticks_left = ticks_left - TW'(1);
                settle();
            end
        end else if (phase_q == PH_IDLE) begin
            r.accepted = 1'b1;
            if (w.message_id == MSG_MAIN) begin
                main_held    = w.crc_value;
                pair_seen[0] = 1'b1;
            end else begin
                alt_held     = w.crc_value;
                pair_seen[1] = 1'b1;
            end
            if (pair_seen == 2'b11) begin
                r.check_done = 1'b1;
                main_shown   = main_held;
                alt_shown    = alt_held;
                pass_q       = (main_held == cfg_q.expected_crc) && (alt_held != main_held);
                pair_seen    = 2'b00;
                if (pass_q) begin
                    bit_idx = BIT_MSB;
                    start_bit();
                end else begin
                    phase_q    = PH_BLINK;
                    toggles_q  = cfg_q.blink_toggle_count;
                    ticks_left = '0;
                end
                settle();
            end
        end
        r.led_lit         = led_q;
        r.busy_res        = (phase_q != PH_IDLE);
        r.check_ok        = pass_q;
        r.main_crc_out    = main_shown;
        r.altered_crc_out = alt_shown;
        return r;
    endfunction

    function automatic int field_bad(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        int        bad;
        if (!i_rst_n) begin
            cfg_q = {RST_ONE_PULSE, RST_ZERO_PULSE, RST_BIT_GAP, RST_FRAME_GAP,
                     RST_BLINK_INTERVAL, RST_BLINK_TOGGLES, RST_EXPECTED_CRC};
            pair_seen  = 2'b00;
            main_held  = 8'h00;
            alt_held   = 8'h00;
            main_shown = 8'h00;
            alt_shown  = 8'h00;
            pass_q     = 1'b0;
            phase_q    = PH_IDLE;
            bit_idx    = BIT_MSB;
            ticks_left = '0;
            toggles_q  = 8'h00;
            led_q      = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ONE_PULSE:      cfg_q.one_pulse_ticks      = i_cfg_wdata;
                    CFG_ZERO_PULSE:     cfg_q.zero_pulse_ticks     = i_cfg_wdata;
                    CFG_BIT_GAP:        cfg_q.bit_gap_ticks        = i_cfg_wdata;
                    CFG_FRAME_GAP:      cfg_q.frame_gap_ticks      = i_cfg_wdata;
                    CFG_BLINK_INTERVAL: cfg_q.blink_interval_ticks = i_cfg_wdata;
                    CFG_BLINK_TOGGLES:  cfg_q.blink_toggle_count   = i_cfg_wdata[7:0];
                    CFG_EXPECTED_CRC:   cfg_q.expected_crc         = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(predict_word(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h, expected none", $time, i_out_data);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    bad  = field_bad("led_lit", 8'(want.led_lit), 8'(i_out_data.led_lit))
                         + field_bad("accepted", 8'(want.accepted), 8'(i_out_data.accepted))
                         + field_bad("busy_res", 8'(want.busy_res), 8'(i_out_data.busy_res))
                         + field_bad("check_done", 8'(want.check_done),
                                     8'(i_out_data.check_done))
                         + field_bad("check_ok", 8'(want.check_ok), 8'(i_out_data.check_ok))
                         + field_bad("main_crc_out", want.main_crc_out,
                                     i_out_data.main_crc_out)
                         + field_bad("altered_crc_out", want.altered_crc_out,
                                     i_out_data.altered_crc_out);
                    if (bad != 0)
                        o_errors = o_errors + 1;
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import crcpl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam logic MSG_ALTERED     = ~MSG_MAIN;
    localparam int   HOLD_CYCLES     = 300;
    localparam int   WATCHDOG_LIMIT  = 4000;
    localparam int   SETTLE_CYCLES   = 8;
    localparam int   WORDS_PER_PHASE = 50;
    localparam int   BURST_CAP       = 60;
    localparam int   DRAIN_CAP       = 120;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_word              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   errors;
    int   pending;
    logic in_took      = 1'b0;
    int   quiet_cycles = 0;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   hold_asked   = 0;
    int   hold_done    = 0;
    int   words_sent   = 0;
    logic pass_allowed = 1'b1;
    t_cfg cfg_now;

    crc_pair_check_led_pulse_coder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    crcpl_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        in_took <= in_valid && !in_stall;
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // a long hold-off, when asked, lets both stages fill and stall the input
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_asked) begin
                hold_done = hold_asked;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_word(input logic req, input logic [7:0] crc, input logic id);
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid           = 1'b1;
        in_data.req_type   = req;
        in_data.crc_value  = crc;
        in_data.message_id = id;
        do @(negedge i_clk); while (!in_took);
        words_sent++;
    endtask

    // where passes are kept out, a main crc never matches the expected value
    task automatic send_result(input logic [7:0] crc, input logic id);
        if (!pass_allowed && id == MSG_MAIN && crc == cfg_now.expected_crc)
            crc = crc ^ 8'h01;
        send_word(REQ_RESULT, crc, id);
    endtask

    task automatic tick_burst(input int n);
        repeat (n) send_word(REQ_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input t_cfg c);
        in_valid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_idx   = CFG_ONE_PULSE;
        cfg_wdata = c.one_pulse_ticks;
        @(negedge i_clk);
        cfg_idx   = CFG_ZERO_PULSE;
        cfg_wdata = c.zero_pulse_ticks;
        @(negedge i_clk);
        cfg_idx   = CFG_BIT_GAP;
        cfg_wdata = c.bit_gap_ticks;
        @(negedge i_clk);
        cfg_idx   = CFG_FRAME_GAP;
        cfg_wdata = c.frame_gap_ticks;
        @(negedge i_clk);
        cfg_idx   = CFG_BLINK_INTERVAL;
        cfg_wdata = c.blink_interval_ticks;
        @(negedge i_clk);
        cfg_idx   = CFG_BLINK_TOGGLES;
        cfg_wdata = {8'($urandom_range(255)), c.blink_toggle_count};
        @(negedge i_clk);
        cfg_idx   = CFG_EXPECTED_CRC;
        cfg_wdata = {8'($urandom_range(255)), c.expected_crc};
        @(negedge i_clk);
        // unmapped index, must leave every register alone
        cfg_idx   = CFG_NO_REG;
        cfg_wdata = 16'($urandom_range(65535));
        @(negedge i_clk);
        cfg_we  = 1'b0;
        cfg_now = c;
    endtask

    // ticks that cover the longest display or blink under a setting
    function automatic int pattern_ticks(input t_cfg c, input logic shows);
        int pulse;
        int shown;
        int blink;
        pulse = (c.one_pulse_ticks > c.zero_pulse_ticks) ? int'(c.one_pulse_ticks)
                                                         : int'(c.zero_pulse_ticks);
        shown = shows ? 8 * (pulse + int'(c.bit_gap_ticks)) + int'(c.frame_gap_ticks) : 0;
        blink = int'(c.blink_toggle_count) * int'(c.blink_interval_ticks);
        return ((shown > blink) ? shown : blink) + 2;
    endfunction

    initial begin : stimulus
        t_cfg       c;
        int         phase;
        int         r;
        int         plen;
        int         burst_max;
        int         stop_at;
        logic [7:0] main_pick;
        logic [7:0] alt_pick;

        cfg_now = {RST_ONE_PULSE, RST_ZERO_PULSE, RST_BIT_GAP, RST_FRAME_GAP,
                   RST_BLINK_INTERVAL, RST_BLINK_TOGGLES, RST_EXPECTED_CRC};
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: tick while idle, a failing pair, a word refused mid-blink
        send_word(REQ_TICK, 8'hFF, MSG_ALTERED);
        send_result(8'hFF, MSG_ALTERED);
        send_result(8'h00, MSG_MAIN);
        send_result(cfg_now.expected_crc, MSG_MAIN);
        tick_burst(3);
        // a short interval cuts the running blink down before the phases
        wait_drained();
        c = cfg_now;
        c.blink_interval_ticks = 16'd1;
        load_settings(c);

        for (phase = 1; phase < 10; phase++) begin
            plen = pattern_ticks(cfg_now, pass_allowed);
            tick_burst((plen < DRAIN_CAP) ? plen : DRAIN_CAP);
            wait_drained();
            case (phase)
                1: c = {16'd3, 16'd1, 16'd1, 16'd2, 16'd2, 8'd3, 8'hA5};
                2: c = {16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 8'd0, 8'h00};
                3: c = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'hFF};
                4: c = {16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 8'd255, 8'hFF};
                default: begin
                    c.one_pulse_ticks      = 16'($urandom_range(0, 6));
                    c.zero_pulse_ticks     = 16'($urandom_range(0, 6));
                    c.bit_gap_ticks        = 16'($urandom_range(0, 5));
                    c.frame_gap_ticks      = 16'($urandom_range(0, 5));
                    c.blink_interval_ticks = 16'($urandom_range(1, 4));
                    c.blink_toggle_count   = 8'($urandom_range(0, 6));
                    c.expected_crc         = 8'($urandom_range(255));
                end
            endcase
            load_settings(c);
            // all-max durations would run for ages, so that setting only sees fails
            pass_allowed = (phase != 3);
            idle_pct  = (phase % 4 == 1) ? 49 : (phase % 4 == 3) ? 31 : 0;
            stall_pct = (phase % 4 == 2) ? 49 : (phase % 4 == 3) ? 31 : 0;
            plen      = pattern_ticks(c, pass_allowed);

            if (phase == 1) begin
                // pass shows a5 msb first, a word during the display is refused
                send_result(8'hA5, MSG_MAIN);
                send_result(8'h5A, MSG_ALTERED);
                send_result(8'h00, MSG_MAIN);
                tick_burst(plen);
                // altered first and equal to main
                send_result(8'hA5, MSG_ALTERED);
                send_result(8'hA5, MSG_MAIN);
                tick_burst(plen);
                // main overwritten before the pair completes
                send_result(8'h00, MSG_MAIN);
                send_result(8'hA5, MSG_MAIN);
                send_result(8'hFF, MSG_ALTERED);
                tick_burst(plen);
                // wrong main crc
                send_result(8'hFF, MSG_MAIN);
                send_result(8'h00, MSG_ALTERED);
                tick_burst(plen);
            end
            if (phase == 2) begin
                // zero durations: display and blink both end on the starting word
                send_result(8'h00, MSG_MAIN);
                send_result(8'h01, MSG_ALTERED);
                send_result(8'h01, MSG_MAIN);
                send_result(8'h02, MSG_ALTERED);
            end
            if (phase == 4)
                hold_asked++;

            burst_max = pass_allowed ? plen + plen / 2 : 4;
            if (burst_max > BURST_CAP)
                burst_max = BURST_CAP;
            stop_at = words_sent + WORDS_PER_PHASE;
            while (words_sent < stop_at) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    main_pick = (pass_allowed && $urandom_range(99) < 75)
                              ? cfg_now.expected_crc : 8'($urandom_range(255));
                    alt_pick  = ($urandom_range(99) < 15) ? main_pick : 8'($urandom_range(255));
                    if ($urandom_range(1)) begin
                        send_result(main_pick, MSG_MAIN);
                        send_result(alt_pick, MSG_ALTERED);
                    end else begin
                        send_result(alt_pick, MSG_ALTERED);
                        send_result(main_pick, MSG_MAIN);
                    end
                    tick_burst($urandom_range(burst_max / 2, burst_max));
                end else if (r < 85) begin
                    tick_burst($urandom_range(1, 8));
                end else begin
                    send_result(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
        end

        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> crc_pair_check_led_pulse_coder_core.f
+incdir+hdl
hdl/crcpl_pkg.sv
hdl/crcpl_cfg.sv
hdl/crcpl_engine.sv
hdl/crc_pair_check_led_pulse_coder_core.sv
tb/sv/crcpl_checker.sv
tb/sv/tb_top.sv
